FILE: hw/rtl/flow_tracking_table_core_defines.svh
`ifndef FLOW_TRACKING_TABLE_CORE_DEFINES_SVH
`define FLOW_TRACKING_TABLE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define FTT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define FTT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define FTT_ASSERT(lbl, clk, rst, prop, msg)

`define FTT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

FILE: hw/rtl/ftt_pkg.sv
package ftt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = IDX_W + 1;

  localparam logic [7:0] FLAG_SYN = 8'h02;
  localparam logic [7:0] FLAG_ACK = 8'h10;
  localparam logic [7:0] FLAG_FIN = 8'h01;
  localparam logic [7:0] FLAG_RST = 8'h04;

  localparam logic [2:0] CS_UNKNOWN     = 3'd0;
  localparam logic [2:0] CS_SYN_SENT    = 3'd1;
  localparam logic [2:0] CS_ESTABLISHED = 3'd2;
  localparam logic [2:0] CS_FIN_WAIT    = 3'd3;
  localparam logic [2:0] CS_CLOSING     = 3'd4;
  localparam logic [2:0] CS_RESET       = 3'd5;
  localparam logic [2:0] CS_UDP         = 3'd6;

  typedef struct packed {
    logic        udp;
    logic [31:0] lo_addr;
    logic [31:0] hi_addr;
    logic [31:0] ports;
  } key_t;

  typedef struct packed {
    key_t        key;
    logic [7:0]  flags;
    logic [15:0] len;
    logic [31:0] ts;
  } item_t;

  typedef struct packed {
    logic [31:0] pkts;
    logic [47:0] bytes;
    logic [31:0] first;
    logic [31:0] last;
    logic [2:0]  cstate;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FETCH, ST_UPD} back_state_t;

  localparam int KEY_W = $bits(key_t);
  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [2:0] next_tcp_state(input logic [2:0] cur, input logic [7:0] f);
    logic [2:0] r;
    r = cur;
    if ((f & FLAG_RST) != 8'h00) r = CS_RESET;
    else if ((f & FLAG_FIN) != 8'h00 && (f & FLAG_ACK) != 8'h00) r = CS_CLOSING;
    else if ((f & FLAG_FIN) != 8'h00) r = CS_FIN_WAIT;
    else if ((f & FLAG_SYN) != 8'h00 && (f & FLAG_ACK) != 8'h00) r = CS_ESTABLISHED;
    else if ((f & FLAG_SYN) != 8'h00) r = CS_SYN_SENT;
    else if ((f & FLAG_ACK) != 8'h00 && (cur == CS_SYN_SENT || cur == CS_UNKNOWN))
      r = CS_ESTABLISHED;
    return r;
  endfunction

endpackage

FILE: hw/rtl/ftt_ram.sv
module ftt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/ftt_front.sv
module ftt_front import ftt_pkg::*; (
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [31:0] source_address,
  input  logic [31:0] dest_address,
  input  logic [15:0] source_port,
  input  logic [15:0] dest_port,
  input  logic [7:0]  tcp_flag_bits,
  input  logic [15:0] packet_length,
  input  logic [31:0] timestamp,
  input  q_status_t   q_status,
  output logic        push,
  output item_t       push_item
);

  logic keep;

  assign keep = (source_address < dest_address) ||
                (source_address == dest_address && source_port < dest_port);

  always_comb begin
    push_item.key.udp = req_type;
    if (keep) begin
      push_item.key.lo_addr = source_address;
      push_item.key.hi_addr = dest_address;
      push_item.key.ports   = {source_port, dest_port};
    end else begin
      push_item.key.lo_addr = dest_address;
      push_item.key.hi_addr = source_address;
      push_item.key.ports   = {dest_port, source_port};
    end
    push_item.flags = tcp_flag_bits;
    push_item.len   = packet_length;
    push_item.ts    = timestamp;
  end

  assign in_stall = q_status.full;
  assign push     = in_valid && !q_status.full;

endmodule

FILE: hw/rtl/ftt_queue.sv
module ftt_queue import ftt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  item_t     push_item,
  input  logic      pop,
  output item_t     pop_item,
  output q_status_t q_status
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_status.full  = (count == 2'd2);
  assign q_status.empty = (count == 2'd0);
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: hw/rtl/ftt_back.sv
`include "flow_tracking_table_core_defines.svh"

module ftt_back import ftt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  q_status_t   q_status,
  input  item_t       pop_item,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  flow_index,
  output logic        new_flow,
  output logic        table_full,
  output logic [31:0] flow_packets,
  output logic [47:0] flow_bytes,
  output logic [2:0]  flow_state,
  output logic [31:0] first_seen_time
);

  back_state_t state, state_next;
  item_t       cur, cur_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic        cmp_vld, cmp_vld_next;
  logic [IDX_W-1:0] cmp_idx, cmp_idx_next;
  logic        hit_found, hit_found_next;
  logic [IDX_W-1:0] hit_idx, hit_idx_next;
  logic        free_found, free_found_next;
  logic [IDX_W-1:0] free_idx, free_idx_next;
  logic [TABLE_ENTRIES-1:0] valid, valid_next;
  logic        res_valid, res_valid_next;
  logic        load;

  logic [IDX_W-1:0] tgt;
  logic [KEY_W-1:0] key_rd;
  entry_t      ent_rd;
  logic [ENTRY_W-1:0] ent_rd_raw;
  logic        key_we, ent_we;
  entry_t      base, upd;
  logic [48:0] bsum;
  logic        full;

  assign tgt  = hit_found ? hit_idx : free_idx;
  assign full = !hit_found && !free_found;
  assign ent_rd = entry_t'(ent_rd_raw);

  ftt_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (tgt),
    .wdata (cur.key),
    .raddr (cnt[IDX_W-1:0]),
    .rdata (key_rd)
  );

  ftt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (tgt),
    .wdata (upd),
    .raddr (tgt),
    .rdata (ent_rd_raw)
  );

  always_comb begin
    if (!hit_found) begin
      base.pkts   = '0;
      base.bytes  = '0;
      base.first  = cur.ts;
      base.last   = cur.ts;
      base.cstate = cur.key.udp ? CS_UDP : CS_UNKNOWN;
    end else begin
      base = ent_rd;
    end
    upd.pkts  = (base.pkts == '1) ? base.pkts : base.pkts + 32'd1;
    bsum      = {1'b0, base.bytes} + 49'(cur.len);
    upd.bytes = bsum[48] ? '1 : bsum[47:0];
    upd.first = base.first;
    upd.last  = cur.ts;
    upd.cstate = cur.key.udp ? base.cstate : next_tcp_state(base.cstate, cur.flags);
  end

  always_comb begin
    state_next      = state;
    cur_next        = cur;
    cnt_next        = cnt;
    cmp_vld_next    = 1'b0;
    cmp_idx_next    = cmp_idx;
    hit_found_next  = hit_found;
    hit_idx_next    = hit_idx;
    free_found_next = free_found;
    free_idx_next   = free_idx;
    valid_next      = valid;
    pop             = 1'b0;
    load            = 1'b0;
    key_we          = 1'b0;
    ent_we          = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!q_status.empty) begin
          pop             = 1'b1;
          cur_next        = pop_item;
          cnt_next        = '0;
          hit_found_next  = 1'b0;
          free_found_next = 1'b0;
          state_next      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt < CNT_W'(TABLE_ENTRIES)) begin
          cnt_next     = cnt + 1'b1;
          cmp_vld_next = 1'b1;
          cmp_idx_next = cnt[IDX_W-1:0];
        end
        if (cmp_vld) begin
          if (valid[cmp_idx]) begin
            if (!hit_found && key_rd == cur.key) begin
              hit_found_next = 1'b1;
              hit_idx_next   = cmp_idx;
            end
          end else if (!free_found) begin
            free_found_next = 1'b1;
            free_idx_next   = cmp_idx;
          end
        end
        if (cnt == CNT_W'(TABLE_ENTRIES) && !cmp_vld) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_UPD;
      end
      ST_UPD: begin
        if (!res_valid || !out_stall) begin
          load       = 1'b1;
          state_next = ST_IDLE;
          if (!full) begin
            ent_we = 1'b1;
            key_we = !hit_found;
            valid_next[tgt] = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    res_valid_next = (res_valid && out_stall) || load;
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    cnt      <= cnt_next;
    cmp_idx  <= cmp_idx_next;
    hit_idx  <= hit_idx_next;
    free_idx <= free_idx_next;
    if (load) begin
      table_full <= full;
      if (full) begin
        flow_index      <= '0;
        new_flow        <= 1'b0;
        flow_packets    <= '0;
        flow_bytes      <= '0;
        flow_state      <= '0;
        first_seen_time <= '0;
      end else begin
        flow_index      <= 6'(tgt);
        new_flow        <= !hit_found;
        flow_packets    <= upd.pkts;
        flow_bytes      <= upd.bytes;
        flow_state      <= upd.cstate;
        first_seen_time <= upd.first;
      end
    end
    if (rst) begin
      state      <= ST_IDLE;
      cmp_vld    <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      valid      <= '0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cmp_vld    <= cmp_vld_next;
      hit_found  <= hit_found_next;
      free_found <= free_found_next;
      valid      <= valid_next;
      res_valid  <= res_valid_next;
    end
  end

  assign out_valid = res_valid;

  `FTT_NEVER(a_pop_idle, clk, rst, pop && state != ST_IDLE, "pop outside idle")
  `FTT_ASSERT(a_full_clean, clk, rst, out_valid && table_full |-> !new_flow && flow_packets == 32'd0, "full result carries data")
  `FTT_ASSERT(a_new_one, clk, rst, out_valid && new_flow |-> flow_packets == 32'd1, "new flow count not one")
  `FTT_ASSERT(a_load_free, clk, rst, load |-> !res_valid || !out_stall, "result overwritten")

endmodule

FILE: hw/rtl/flow_tracking_table_core.sv
// channel | handshake                       | beat
// in      | in_valid / in_stall             | one packet header
// out     | out_valid / out_stall           | one flow entry report
// An item's processing time is set by the key scan, which reads the stored keys
// through the single read port of the key memory, one entry per cycle.
// Two headers queue ahead of the back end; the result register frees the scan from out_stall.
// Reset clears the entry valid bits at once; no clearing pass.
module flow_tracking_table_core import ftt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [31:0] source_address,
  input  logic [31:0] dest_address,
  input  logic [15:0] source_port,
  input  logic [15:0] dest_port,
  input  logic [7:0]  tcp_flag_bits,
  input  logic [15:0] packet_length,
  input  logic [31:0] timestamp,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  flow_index,
  output logic        new_flow,
  output logic        table_full,
  output logic [31:0] flow_packets,
  output logic [47:0] flow_bytes,
  output logic [2:0]  flow_state,
  output logic [31:0] first_seen_time
);

  q_status_t q_status;
  logic      push;
  logic      pop;
  item_t     push_item;
  item_t     pop_item;

  ftt_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .req_type       (req_type),
    .source_address (source_address),
    .dest_address   (dest_address),
    .source_port    (source_port),
    .dest_port      (dest_port),
    .tcp_flag_bits  (tcp_flag_bits),
    .packet_length  (packet_length),
    .timestamp      (timestamp),
    .q_status       (q_status),
    .push           (push),
    .push_item      (push_item)
  );

  ftt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_status  (q_status)
  );

  ftt_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_status        (q_status),
    .pop_item        (pop_item),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .flow_index      (flow_index),
    .new_flow        (new_flow),
    .table_full      (table_full),
    .flow_packets    (flow_packets),
    .flow_bytes      (flow_bytes),
    .flow_state      (flow_state),
    .first_seen_time (first_seen_time)
  );

endmodule
